[design/prtk_pkg.sv]
// Package for the per-row top-k extremes block.
// Holds the item types, opcodes and register indexes; depends on nothing.
`timescale 1ns / 1ps

package prtk_pkg;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_KEEP_SMALLEST = 1'b0,
    REG_SLOTS_IN_USE  = 1'b1
  } reg_index_t;

  localparam logic signed [31:0] SENT_MAX_MODE = 32'sh8000_0000;
  localparam logic signed [31:0] SENT_MIN_MODE = 32'sh7fff_ffff;
  localparam logic [3:0]         SLOTS_RESET   = 4'd8;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         row_index;
    logic signed [31:0] sample_value;
    logic [2:0]         slot_index;
  } cmd_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         insert_slot;
    logic signed [31:0] read_value;
  } rsp_t;

endpackage

[design/per_row_top_k_extremes.sv]
// Top level of the per-row top-k extremes block: row memory, insertion logic, control.
// Depends on prtk_pkg.
`timescale 1ns / 1ps

// Usage:
// An item on cmd is taken at a rising edge where start is high and busy is low.
// The addressed row is read from a synchronous memory, the sorted list
// is updated in the next cycle and written back, and the result appears on rsp
// with done high for exactly one cycle, registered at the end of the update state.
// busy stays high in between, so a new item is taken only once the previous one is
// through; the row read-modify-write sets this.
// The receiver cannot stall: each result must be taken in the cycle it is shown.
// Configuration writes go over cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 selects min or max mode, index 1 the number of kept slots.
// After reset a clearing pass writes the max-mode sentinel into every row, one row
// per cycle; busy is high during the pass, while configuration writes are still
// taken.
module per_row_top_k_extremes #(
  parameter int MAX_SLOTS = 8,
  parameter int NUM_ROWS  = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  prtk_pkg::cmd_t cmd,
  output logic           done,
  output prtk_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_data
);
  import prtk_pkg::*;

  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int WORD_W = MAX_SLOTS * 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic [ROW_W-1:0] clr_row;
  cmd_t             cur;

  logic             keep_smallest;
  logic [3:0]       slots_in_use;

  logic [WORD_W-1:0] mem [0:NUM_ROWS-1];
  logic [WORD_W-1:0] rdata;
  logic [ROW_W-1:0]  raddr;
  logic              we;
  logic [ROW_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;

  logic signed [31:0] list     [MAX_SLOTS];
  logic signed [31:0] new_list [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] beat;
  logic [CNT_W-1:0]   n_act;
  logic [CNT_W-1:0]   k;
  logic [7:0]         k_ext;
  logic [5:0]         siu_ext;
  logic               row_ok;
  logic               do_ins;
  logic signed [31:0] sentinel;
  logic [SLOT_W-1:0]  rd_idx;
  rsp_t               rsp_next;
  logic               exec_we;
  logic [WORD_W-1:0]  exec_word;
  logic [WORD_W-1:0]  clear_word;

  assign busy      = rst || (state != ST_IDLE);
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_smallest <= 1'b0;
      slots_in_use  <= SLOTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEEP_SMALLEST: keep_smallest <= cfg_data[0];
        REG_SLOTS_IN_USE:  slots_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raddr = ROW_W'({10'b0, cmd.row_index});

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    siu_ext  = {2'b0, slots_in_use};
    sentinel = keep_smallest ? SENT_MIN_MODE : SENT_MAX_MODE;
    row_ok   = {10'b0, cur.row_index} < 16'(NUM_ROWS);

    if (siu_ext == 6'd0) begin
      n_act = CNT_W'(1);
    end else if (siu_ext > 6'(MAX_SLOTS)) begin
      n_act = CNT_W'(MAX_SLOTS);
    end else begin
      n_act = CNT_W'(siu_ext);
    end

    for (int s = 0; s < MAX_SLOTS; s++) begin
      list[s] = rdata[s*32 +: 32];
      beat[s] = keep_smallest ? (cur.sample_value < list[s]) : (cur.sample_value > list[s]);
    end

    k = '0;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (beat[s] && (CNT_W'(s) < n_act)) begin
        k = CNT_W'(s);
      end
    end
    k_ext  = 8'(k);
    do_ins = (cur.opcode == OP_OFFER) && beat[0];

    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (CNT_W'(s) < k) begin
        new_list[s] = list[(s + 1) % MAX_SLOTS];
      end else if (CNT_W'(s) == k) begin
        new_list[s] = cur.sample_value;
      end else begin
        new_list[s] = list[s];
      end
    end

    for (int s = 0; s < MAX_SLOTS; s++) begin
      exec_word[s*32 +: 32]  = (cur.opcode == OP_CLEAR) ? sentinel : new_list[s];
      clear_word[s*32 +: 32] = SENT_MAX_MODE;
    end

    rd_idx   = SLOT_W'({3'b0, cur.slot_index});
    rsp_next = '0;
    exec_we  = 1'b0;
    if (row_ok) begin
      unique case (cur.opcode)
        OP_OFFER: begin
          exec_we              = do_ins;
          rsp_next.accepted    = do_ins;
          rsp_next.insert_slot = do_ins ? k_ext[2:0] : 3'd0;
          rsp_next.read_value  = do_ins ? new_list[0] : list[0];
        end
        OP_READ: begin
          if ({3'b0, cur.slot_index} < 6'(MAX_SLOTS)) begin
            rsp_next.read_value = list[rd_idx];
          end
        end
        OP_CLEAR: begin
          exec_we             = 1'b1;
          rsp_next.read_value = sentinel;
        end
        OP_NOP: begin
          rsp_next.read_value = list[0];
        end
        default: ;
      endcase
    end

    we    = 1'b0;
    waddr = clr_row;
    wdata = clear_word;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (state == ST_EXEC) begin
      we    = exec_we;
      waddr = ROW_W'({10'b0, cur.row_index});
      wdata = exec_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (clr_row == ROW_W'(NUM_ROWS - 1)) begin
            state <= ST_IDLE;
          end
          clr_row <= clr_row + 1'b1;
        end
        ST_IDLE: begin
          if (start) begin
            cur   <= cmd;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rsp   <= rsp_next;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/prtk_checker.sv]
// Port-level checker for the per-row top-k extremes block, with its bind statement.
// Depends on prtk_pkg and the top level per_row_top_k_extremes.
`timescale 1ns / 1ps

module prtk_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input prtk_pkg::rsp_t rsp
);
  import prtk_pkg::*;

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an item was taken");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result did not appear two cycles after the item was taken");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done was high for more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while the block is busy");

  a_slot_zero_on_reject: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.accepted) |-> (rsp.insert_slot == 3'd0))
    else $error("nonzero insert slot on a rejected item");

endmodule

bind per_row_top_k_extremes prtk_checker u_prtk_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

[bench/per_row_top_k_extremes_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for per_row_top_k_extremes: directed and random items under
// several mode and slot-count settings, each result checked against a local model.
// Depends on prtk_pkg and the per_row_top_k_extremes RTL.

import prtk_pkg::*;

class top_k_tracker;
  localparam int ROW_COUNT  = 64;
  localparam int SLOT_COUNT = 8;

  logic signed [31:0] rows [ROW_COUNT][SLOT_COUNT];
  logic               keep_smallest;
  logic [3:0]         slots_in_use;
  rsp_t               pending [$];
  int unsigned        mismatches;

  function new();
    keep_smallest = 1'b0;
    slots_in_use  = SLOTS_RESET;
    mismatches    = 0;
    foreach (rows[r, s]) rows[r][s] = SENT_MAX_MODE;
  endfunction

  function void write_register(reg_index_t idx, logic [3:0] data);
    if (idx == REG_KEEP_SMALLEST) begin
      keep_smallest = data[0];
    end else begin
      slots_in_use = data;
    end
  endfunction

  function bit stronger(logic signed [31:0] a, logic signed [31:0] b);
    return keep_smallest ? (a < b) : (a > b);
  endfunction

  function void note_command(cmd_t c);
    rsp_t               want;
    int                 kept;
    int                 k;
    int                 r;
    logic signed [31:0] v;
    logic signed [31:0] fill;
    want = '0;
    r    = int'(c.row_index);
    v    = c.sample_value;
    case (opcode_t'(c.opcode))
      OP_OFFER: begin
        if (stronger(v, rows[r][0])) begin
          kept = (slots_in_use == 0) ? 1 :
                 (slots_in_use > SLOT_COUNT) ? SLOT_COUNT : int'(slots_in_use);
          k = kept - 1;
          while (!stronger(v, rows[r][k])) k--;
          for (int j = 1; j <= k; j++) rows[r][j - 1] = rows[r][j];
          rows[r][k]       = v;
          want.accepted    = 1'b1;
          want.insert_slot = k[2:0];
        end
        want.read_value = rows[r][0];
      end
      OP_READ: begin
        want.read_value = rows[r][c.slot_index];
      end
      OP_CLEAR: begin
        fill = keep_smallest ? SENT_MIN_MODE : SENT_MAX_MODE;
        for (int s = 0; s < SLOT_COUNT; s++) rows[r][s] = fill;
        want.read_value = fill;
      end
      default: begin
        want.read_value = rows[r][0];
      end
    endcase
    pending.push_back(want);
  endfunction

  function void check_response(rsp_t got);
    rsp_t want;
    if (pending.size() == 0) begin
      mismatches++;
      $display("%0t: result with none expected: accepted=%0b slot=%0d value=%0d",
               $time, got.accepted, got.insert_slot, got.read_value);
      return;
    end
    want = pending.pop_front();
    if (got.accepted !== want.accepted || got.insert_slot !== want.insert_slot ||
        got.read_value !== want.read_value) begin
      mismatches++;
      $display("%0t: expected acc=%0b slot=%0d value=%0d, got acc=%0b slot=%0d value=%0d",
               $time, want.accepted, want.insert_slot, want.read_value,
               got.accepted, got.insert_slot, got.read_value);
    end
  endfunction
endclass

module per_row_top_k_extremes_test;
  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         start     = 1'b0;
  logic         busy;
  cmd_t         cmd       = '0;
  logic         done;
  rsp_t         rsp;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = 1'b0;
  logic [3:0]   cfg_data  = '0;

  top_k_tracker tracker   = new();
  int unsigned  quiet_left = 0;
  logic [5:0]   hot_rows [4];

  always #10 clk = ~clk;

  per_row_top_k_extremes i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_response(rsp);
    end
  end

  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    if (quiet_left == 0 && $urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(5, 30);
    end
    if (quiet_left != 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    tracker.note_command(c);
  endtask

  task automatic issue(input opcode_t op, input logic [5:0] row,
                       input logic signed [31:0] value, input logic [2:0] slot);
    cmd_t c;
    c.opcode       = op;
    c.row_index    = row;
    c.sample_value = value;
    c.slot_index   = slot;
    send_cmd(c);
  endtask

  task automatic stop_and_drain();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [3:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.write_register(idx, data);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.opcode = (pick < 62) ? OP_OFFER : (pick < 85) ? OP_READ :
               (pick < 93) ? OP_CLEAR : OP_NOP;
    c.row_index = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) :
                  hot_rows[$urandom_range(0, 3)];
    case ($urandom_range(0, 3))
      0: c.sample_value = $urandom();
      1: c.sample_value = int'($urandom_range(0, 31)) - 16;
      2: c.sample_value = $urandom_range(0, 1) ? SENT_MIN_MODE - int'($urandom_range(0, 3)) :
                                                 SENT_MAX_MODE + int'($urandom_range(0, 3));
      default: c.sample_value = (int'($urandom_range(0, 200)) - 100) * 65536;
    endcase
    c.slot_index = 3'($urandom_range(0, 7));
    return c;
  endfunction

  initial begin
    logic [3:0]  slot_setting [12];
    logic        mode_setting [12];
    slot_setting = '{4'd8, 4'd8, 4'd1, 4'd1, 4'd0, 4'd15, 4'd4, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0};
    mode_setting = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    issue(OP_READ,  6'd0,  32'sd0, 3'd0);
    issue(OP_READ,  6'd63, 32'sd0, 3'd7);
    issue(OP_OFFER, 6'd63, SENT_MAX_MODE, 3'd0);
    issue(OP_OFFER, 6'd63, SENT_MIN_MODE, 3'd7);
    issue(OP_OFFER, 6'd63, 32'sd0, 3'd0);
    issue(OP_OFFER, 6'd63, 32'sd0, 3'd0);
    issue(OP_OFFER, 6'd63, -32'sd1, 3'd0);
    issue(OP_OFFER, 6'd63, 32'sh0001_0000, 3'd0);
    issue(OP_READ,  6'd63, 32'sd0, 3'd5);
    issue(OP_NOP,   6'd63, 32'sd0, 3'd0);
    issue(OP_CLEAR, 6'd63, 32'sd0, 3'd0);
    issue(OP_READ,  6'd63, 32'sd0, 3'd3);
    stop_and_drain();

    write_reg(REG_SLOTS_IN_USE, 4'd2);
    issue(OP_OFFER, 6'd1, 32'sd5, 3'd0);
    issue(OP_OFFER, 6'd1, 32'sd7, 3'd0);
    issue(OP_OFFER, 6'd1, 32'sd6, 3'd0);
    issue(OP_OFFER, 6'd1, 32'sd3, 3'd0);
    issue(OP_READ,  6'd1, 32'sd0, 3'd1);
    stop_and_drain();

    write_reg(REG_KEEP_SMALLEST, 4'b1111);
    write_reg(REG_SLOTS_IN_USE, 4'd0);
    issue(OP_OFFER, 6'd1, -32'sd7, 3'd0);
    issue(OP_CLEAR, 6'd2, 32'sd0, 3'd0);
    issue(OP_OFFER, 6'd2, 32'sd10, 3'd0);
    issue(OP_OFFER, 6'd2, 32'sd5, 3'd0);
    issue(OP_OFFER, 6'd2, 32'sd5, 3'd0);
    issue(OP_OFFER, 6'd2, SENT_MAX_MODE, 3'd0);
    issue(OP_READ,  6'd2, 32'sd0, 3'd1);
    stop_and_drain();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase >= 8) begin
        slot_setting[phase] = 4'($urandom_range(0, 15));
        mode_setting[phase] = 1'($urandom_range(0, 1));
      end
      write_reg(REG_KEEP_SMALLEST, {3'($urandom_range(0, 7)), mode_setting[phase]});
      write_reg(REG_SLOTS_IN_USE, slot_setting[phase]);
      foreach (hot_rows[i]) hot_rows[i] = 6'($urandom_range(0, 63));
      for (int n = 0; n < 125; n++) begin
        send_cmd(random_cmd());
        if ($urandom_range(0, 99) == 0) begin
          stop_and_drain();
        end
      end
      stop_and_drain();
    end

    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
